// File: hdl/lfu_cache_table_assert.svh
// assertion macros for the lfu cache table
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LFUCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lfu cache table assertion failed");
`define LFUCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lfu cache table forbidden condition");
`else
`define LFUCT_ASSERT(lbl, clk, rst_n, prop)
`define LFUCT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: hdl/lfuct_pkg.sv
package lfuct_pkg;

  localparam logic        OP_GET     = 1'b0;
  localparam logic        OP_PUT     = 1'b1;
  localparam logic [4:0]  CAP_RESET  = 5'd16;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_INIT = 32'd1;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

// File: hdl/lfuct_req_if.sv
interface lfuct_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic        [31:0] key;
  logic signed [31:0] write_value;

  modport source (output valid, output opcode, output key, output write_value, input ready);
  modport sink (input valid, input opcode, input key, input write_value, output ready);
endinterface

// File: hdl/lfuct_rsp_if.sv
interface lfuct_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

// File: hdl/lfu_cache_table.sv
// lfu cache table: key/value store with least-frequently-used replacement
// req_i carries one request (opcode get/put, key, write_value) by valid/ready;
// rsp_o returns one response (hit, read_value) per request by valid/ready.
// cfg_we_i/cfg_wdata_i write the capacity register; write it only while idle.
// each request scans every slot through one memory read port and one rank
// comparator, one slot per cycle, then writes back in the decide state.
// each eviction (a put miss while occupancy is at capacity) adds another
// rescan. req_i.ready is high only while idle, so a new request is not
// taken until the previous one has been decided.
// a response waits in an output register: a stalled receiver does not stop
// the next request from being accepted and scanned; only its final decide
// step, not an eviction, holds until the earlier response is taken.
// reset clears all slot valid bits, occupancy and the touch counter, and
// sets capacity to 16; slot memory contents are only read behind a valid bit.
`include "lfu_cache_table_assert.svh"

module lfu_cache_table import lfuct_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  lfuct_req_if.sink   req_i,
  lfuct_rsp_if.source rsp_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_e;

  state_e              state_q;
  logic                op_q;
  logic [31:0]         key_q;
  logic [31:0]         wval_q;
  logic [CW-1:0]       scan_q;
  logic [IW-1:0]       proc_q;
  logic                proc_vld_q;
  logic                found_q;
  logic [IW-1:0]       match_idx_q;
  logic [31:0]         match_val_q;
  logic [31:0]         match_cnt_q;
  logic                free_found_q;
  logic [IW-1:0]       free_idx_q;
  logic                vict_found_q;
  logic [IW-1:0]       vict_idx_q;
  logic [95:0]         vict_rank_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [CW-1:0]       occ_q;
  logic [31:0]         touch_q;
  logic [4:0]          cap_q;
  logic                rsp_valid_q;
  logic                hit_q;
  logic [31:0]         rval_q;

  entry_t              rd_entry;
  entry_t              wr_entry;
  logic [95:0]         rd_rank;
  logic                scan_last;
  logic                rd_issue;
  logic [CW-1:0]       cap_eff;
  logic                cap_zero;
  logic                do_touch;
  logic                do_evict;
  logic                do_insert;
  logic                fire;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [31:0]         touch_nx;

  lfuct_mem #(
    .DEPTH (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_entry),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (rd_entry)
  );

  assign scan_last = (scan_q == CW'(ENTRIES));
  assign rd_issue  = (state_q == S_SCAN) && !scan_last;
  assign rd_rank   = {rd_entry.count, rd_entry.stamp, rd_entry.key};
  assign touch_nx  = touch_q + 32'd1;

  always_comb begin
    if ({27'd0, cap_q} > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign cap_zero  = (cap_eff == '0);
  assign do_touch  = found_q && ((op_q == OP_GET) || !cap_zero);
  assign do_evict  = (op_q == OP_PUT) && !cap_zero && !found_q && (occ_q >= cap_eff);
  assign do_insert = (op_q == OP_PUT) && !cap_zero && !found_q && !(occ_q >= cap_eff);
  assign fire      = (state_q == S_DECIDE) && (do_evict || !rsp_valid_q || rsp_o.ready);
  assign mem_we    = fire && (do_touch || do_insert);
  assign mem_waddr = do_touch ? match_idx_q : free_idx_q;

  always_comb begin
    wr_entry.key   = key_q;
    wr_entry.value = (op_q == OP_PUT) ? wval_q : match_val_q;
    wr_entry.count = do_touch ? sat_inc(match_cnt_q) : COUNT_INIT;
    wr_entry.stamp = touch_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_GET;
      key_q        <= '0;
      wval_q       <= '0;
      scan_q       <= '0;
      proc_q       <= '0;
      proc_vld_q   <= 1'b0;
      found_q      <= 1'b0;
      match_idx_q  <= '0;
      match_val_q  <= '0;
      match_cnt_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      vict_found_q <= 1'b0;
      vict_idx_q   <= '0;
      vict_rank_q  <= '0;
      valid_q      <= '0;
      occ_q        <= '0;
      touch_q      <= '0;
      cap_q        <= CAP_RESET;
      rsp_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      rval_q       <= '0;
    end else begin
      proc_vld_q <= rd_issue;
      proc_q     <= scan_q[IW-1:0];

      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      if (fire && !do_evict) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q         <= req_i.opcode;
            key_q        <= req_i.key;
            wval_q       <= req_i.write_value;
            scan_q       <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            vict_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_last) begin
            scan_q <= scan_q + CW'(1);
          end else begin
            state_q <= S_DECIDE;
          end
          if (proc_vld_q) begin
            if (valid_q[proc_q]) begin
              if (!found_q && (rd_entry.key == key_q)) begin
                found_q     <= 1'b1;
                match_idx_q <= proc_q;
                match_val_q <= rd_entry.value;
                match_cnt_q <= rd_entry.count;
              end
              if (!vict_found_q || (rd_rank < vict_rank_q)) begin
                vict_found_q <= 1'b1;
                vict_idx_q   <= proc_q;
                vict_rank_q  <= rd_rank;
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= proc_q;
            end
          end
        end
        S_DECIDE: begin
          if (fire) begin
            if (mem_we) begin
              touch_q <= touch_nx;
            end
            if (do_evict) begin
              // drop the victim and rescan for the next victim or free slot
              valid_q[vict_idx_q] <= 1'b0;
              occ_q               <= occ_q - CW'(1);
              scan_q              <= '0;
              found_q             <= 1'b0;
              free_found_q        <= 1'b0;
              vict_found_q        <= 1'b0;
              state_q             <= S_SCAN;
            end else begin
              if (do_insert) begin
                valid_q[free_idx_q] <= 1'b1;
                occ_q               <= occ_q + CW'(1);
              end
              hit_q <= found_q;
              if (op_q == OP_PUT) begin
                rval_q <= '0;
              end else if (found_q) begin
                rval_q <= match_val_q;
              end else begin
                rval_q <= MISS_VALUE;
              end
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.read_value = signed'(rval_q);

  `LFUCT_ASSERT(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(occ_q))
  `LFUCT_ASSERT(a_evict_valid_victim, clk_i, rst_ni, (fire && do_evict) |-> (vict_found_q && valid_q[vict_idx_q]))
  `LFUCT_ASSERT(a_insert_free_slot, clk_i, rst_ni, (fire && do_insert) |-> (free_found_q && !valid_q[free_idx_q]))
  `LFUCT_ASSERT(a_rsp_from_decide, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q == S_DECIDE))
  `LFUCT_ASSERT_NEVER(a_no_write_while_scan, clk_i, rst_ni, mem_we && (state_q != S_DECIDE))

endmodule

// File: hdl/lfuct_mem.sv
module lfuct_mem import lfuct_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
